// ----- src/assert_macros.svh -----
// Assertion helpers for the index pool allocator checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_SAME(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) ((pre) |-> (post))) \
    else $error("assertion failed: same-cycle implication");

// Implication checked in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) ((pre) |=> (post))) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- src/ipa_pkg.sv -----
package ipa_pkg;

  localparam int MAX_SLOTS = 256;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int COUNT_W   = $clog2(MAX_SLOTS + 1);
  localparam int IDX_W     = 8;
  localparam int SIZE_W    = 9;

  typedef enum logic [1:0] {
    REQ_ADD      = 2'd0,
    REQ_REMOVE   = 2'd1,
    REQ_TRUNCATE = 2'd2
  } req_type_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_BAD_INDEX  = 3'd2,
    ST_BAD_SIZE   = 3'd3,
    ST_STACK_FULL = 3'd4
  } status_t;

  typedef struct packed {
    req_type_t          req_type;
    logic [IDX_W-1:0]   slot_index;
    logic [SIZE_W-1:0]  new_size;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]   granted_index;
    status_t            status;
    logic [SIZE_W-1:0]  pool_size;
  } rsp_t;

  typedef struct packed {
    logic latch_in;
    logic exec;
    logic pop_read;
    logic pop_take;
    logic push_out;
  } ipa_cmd_t;

  typedef struct packed {
    logic is_add;
    logic stack_empty;
    logic pop_hit;
    logic rsp_free;
  } ipa_sts_t;

endpackage

// ----- src/index_pool_allocator_unit.sv -----
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_t (req_type, slot_index, new_size)
// rsp       out        rsp_valid/rsp_stall   rsp_t (granted_index, status, pool_size)
// cfg       in         cfg_we                cfg_data (pool_capacity)
//
// One transaction in flight: accept, execute, then load the output register.
// Remove, truncate and add with an empty recycle stack execute at once; an add
// with a non-empty stack first pops recycled entries (one stack RAM read each).
// rst is synchronous: size and stack count go to zero, capacity to 256.
// A stalled response holds; a new request is taken while it waits.
module index_pool_allocator_unit import ipa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_t              rsp,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_data
);

  ipa_cmd_t cmd;
  ipa_sts_t sts;

  ipa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ipa_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- src/ipa_ram.sv -----
module ipa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/ipa_ctrl.sv -----
module ipa_ctrl import ipa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  ipa_sts_t sts,
  output ipa_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_CHECK,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_add && !sts.stack_empty) begin
          cmd.pop_read = 1'b1;
          state_next   = S_CHECK;
        end else begin
          cmd.exec   = 1'b1;
          state_next = S_DONE;
        end
      end
      S_CHECK: begin
        priority if (sts.pop_hit) begin
          cmd.pop_take = 1'b1;
          state_next   = S_DONE;
        end else if (!sts.stack_empty) begin
          cmd.pop_read = 1'b1;
        end else begin
          cmd.exec   = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.rsp_free) begin
          cmd.push_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- src/ipa_datapath.sv -----
module ipa_datapath import ipa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_t              rsp,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_data,
  input  ipa_cmd_t          cmd,
  output ipa_sts_t          sts
);

  req_t                req_q;
  rsp_t                res;
  logic [SIZE_W-1:0]   high_water;
  logic [SIZE_W-1:0]   high_water_next;
  logic [COUNT_W-1:0]  recycle_count;
  logic [COUNT_W-1:0]  recycle_count_next;
  logic [COUNT_W-1:0]  count_dec;
  logic [SIZE_W-1:0]   pool_capacity;
  logic [SIZE_W-1:0]   eff_cap;
  logic [SIZE_W-1:0]   slot_ext;
  logic [IDX_W-1:0]    granted;
  status_t             status;
  logic                push_wr;
  logic [IDX_W-1:0]    rd_data;

  assign count_dec = recycle_count - COUNT_W'(1);
  assign eff_cap   = (pool_capacity > SIZE_W'(MAX_SLOTS)) ? SIZE_W'(MAX_SLOTS) : pool_capacity;
  assign slot_ext  = SIZE_W'(req_q.slot_index);

  ipa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_SLOTS)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.exec && push_wr),
    .waddr (recycle_count[SLOT_W-1:0]),
    .wdata (req_q.slot_index),
    .re    (cmd.pop_read),
    .raddr (count_dec[SLOT_W-1:0]),
    .rdata (rd_data)
  );

  always_comb begin
    status             = ST_OK;
    granted            = '0;
    high_water_next    = high_water;
    recycle_count_next = recycle_count;
    push_wr            = 1'b0;
    unique case (req_q.req_type)
      REQ_ADD: begin
        if (high_water >= eff_cap) begin
          status = ST_FULL;
        end else begin
          granted         = high_water[IDX_W-1:0];
          high_water_next = high_water + SIZE_W'(1);
        end
      end
      REQ_REMOVE: begin
        priority if (slot_ext >= high_water) begin
          status = ST_BAD_INDEX;
        end else if (slot_ext == high_water - SIZE_W'(1)) begin
          high_water_next = high_water - SIZE_W'(1);
        end else if (recycle_count >= COUNT_W'(MAX_SLOTS)) begin
          status = ST_STACK_FULL;
        end else begin
          push_wr            = 1'b1;
          recycle_count_next = recycle_count + COUNT_W'(1);
        end
      end
      REQ_TRUNCATE: begin
        if (req_q.new_size > high_water) begin
          status = ST_BAD_SIZE;
        end else begin
          high_water_next = req_q.new_size;
        end
      end
      default: ;
    endcase
  end

  assign sts.is_add      = (req_q.req_type == REQ_ADD);
  assign sts.stack_empty = (recycle_count == '0);
  assign sts.pop_hit     = (SIZE_W'(rd_data) < high_water);
  assign sts.rsp_free    = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_water    <= '0;
      recycle_count <= '0;
      pool_capacity <= SIZE_W'(MAX_SLOTS);
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        pool_capacity <= cfg_data;
      end
      if (cmd.exec) begin
        high_water    <= high_water_next;
        recycle_count <= recycle_count_next;
      end else if (cmd.pop_read) begin
        recycle_count <= count_dec;
      end
      if (cmd.push_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req_q <= req;
    end
    if (cmd.exec) begin
      res <= '{granted_index: granted, status: status, pool_size: high_water_next};
    end else if (cmd.pop_take) begin
      res <= '{granted_index: rd_data, status: ST_OK, pool_size: high_water};
    end
    if (cmd.push_out) begin
      rsp <= res;
    end
  end

endmodule

// ----- src/ipa_checker.sv -----
`include "assert_macros.svh"

module ipa_checker import ipa_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input rsp_t              rsp
);

  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && !req_stall, req_stall)
  `ASSERT_NEXT(a_no_instant_rsp, clk, rst, req_valid && !req_stall, !$rose(rsp_valid))
  `ASSERT_SAME(a_fail_no_grant, clk, rst, rsp_valid && rsp.status != ST_OK, rsp.granted_index == '0)

endmodule

bind index_pool_allocator_unit ipa_checker u_ipa_checker (.*);
